>>> src/generational_handle_slot_map_assert.svh
`ifndef GENERATIONAL_HANDLE_SLOT_MAP_ASSERT_SVH
`define GENERATIONAL_HANDLE_SLOT_MAP_ASSERT_SVH

// immediate-cycle property under clk / arst_n
`define GHSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on the following cycle
`define GHSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ghsm_pkg.sv
package ghsm_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int GEN_BITS_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_TICK    = 2'd2,
		OP_LOOKUP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INVALID    = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_QUEUE_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CR_POP,
		S_CR_GEN,
		S_CR_RDG,
		S_CR_WR,
		S_DS,
		S_LK_RD,
		S_LK_D2S,
		S_LK_CHK,
		S_TK_Q,
		S_TK_S,
		S_TK_D,
		S_TK_C,
		S_TK_M,
		S_TK_W,
		S_DONE
	} state_t;

endpackage

>>> src/ghsm_ram.sv
module ghsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/generational_handle_slot_map.sv
// Sequential handle table; one request at a time, all tables in single-port-read RAMs.
// Each request steps through its own states, one RAM read per dependent step; a tick
// repeats its steps for each queued handle.
// The next request is accepted in the cycle after the result register loads.
// A new request is accepted while the previous result waits in the output register.
// Reset clears the counters and control only; RAM contents are not cleared and no
// clearing pass runs, so the block takes requests right after reset.
module generational_handle_slot_map #(
	parameter int MAX_ENTRIES = ghsm_pkg::MAX_ENTRIES_DEF,
	parameter int GEN_BITS    = ghsm_pkg::GEN_BITS_DEF,
	parameter int QUEUE_DEPTH = ghsm_pkg::QUEUE_DEPTH_DEF,
	localparam int IW = $clog2(MAX_ENTRIES),
	localparam int NW = $clog2(MAX_ENTRIES + 1),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	input  logic [IW-1:0]       handle_index,
	input  logic [GEN_BITS-1:0] handle_gen,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [IW-1:0]       out_handle_index,
	output logic [GEN_BITS-1:0] out_handle_gen,
	output logic [IW-1:0]       dense_index,
	output logic [CW-1:0]       destroyed_count,
	output logic [NW-1:0]       live_count
);
	import ghsm_pkg::*;

	localparam int GW = GEN_BITS;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	state_t state_q, state_d;

	op_t           op_q;
	logic [IW-1:0] idx_q;
	logic [GW-1:0] gen_q;
	logic [IW-1:0] slot_q, pos_q;
	logic [GW-1:0] qgen_q, sgen_q;
	logic [NW-1:0] free_q, used_q, live_q;
	logic [QW-1:0] head_q;
	logic [CW-1:0] cnt_q, rm_q;
	status_t       st_q;
	logic [IW-1:0] res_idx_q, res_dense_q;
	logic [GW-1:0] res_gen_q;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [IW-1:0] out_idx_q, out_dense_q;
	logic [GW-1:0] out_gen_q;
	logic [CW-1:0] out_rm_q;
	logic [NW-1:0] out_live_q;

	// RAM ports
	logic          pos_we, gen_we, d2s_we, free_we, q_we;
	logic [IW-1:0] pos_waddr, gen_waddr, d2s_waddr, sg_raddr, d2s_raddr, free_raddr;
	logic [IW-1:0] pos_wdata, d2s_wdata, free_waddr, free_wdata;
	logic [GW-1:0] gen_wdata;
	logic [IW-1:0] pos_rd, d2s_rd, free_rd;
	logic [GW-1:0] gen_rd;
	logic [QW-1:0] q_waddr;
	logic [IW+GW-1:0] q_wdata, q_rd;

	logic [IW-1:0] q_rd_idx;
	logic [GW-1:0] q_rd_gen;
	logic [NW-1:0] free_dec, last_n;
	logic [IW-1:0] last_pos;
	logic [CW:0]   tsum;
	logic [QW-1:0] tail;
	logic [QW-1:0] head_inc;
	logic          out_load;
	logic          ds_ok, lk_in_range, tk_in_range, pos_live, lk_match, tk_match;
	logic          bal_ok, tk_done;

	assign q_rd_idx = q_rd[IW+GW-1:GW];
	assign q_rd_gen = q_rd[GW-1:0];
	assign free_dec = free_q - 1'b1;
	assign last_n   = live_q - 1'b1;
	assign last_pos = last_n[IW-1:0];
	assign tsum     = (CW+1)'(head_q) + (CW+1)'(cnt_q);
	assign tail     = (tsum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(tsum - (CW+1)'(QUEUE_DEPTH))
		: QW'(tsum);
	assign head_inc = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign ds_ok       = (NW'(idx_q) < used_q) && (cnt_q < CW'(QUEUE_DEPTH));
	assign lk_in_range = NW'(idx_q) < used_q;
	assign tk_in_range = NW'(q_rd_idx) < used_q;
	assign pos_live    = NW'(pos_rd) < live_q;
	assign lk_match    = (d2s_rd == idx_q) && (sgen_q == gen_q);
	assign tk_match    = (d2s_rd == slot_q) && (sgen_q == qgen_q);
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready);

	ghsm_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(sg_raddr), .rdata(pos_rd)
	);
	ghsm_ram #(.WIDTH(GW), .DEPTH(MAX_ENTRIES)) u_gen_ram (
		.clk(clk), .we(gen_we), .waddr(gen_waddr), .wdata(gen_wdata),
		.raddr(sg_raddr), .rdata(gen_rd)
	);
	ghsm_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_d2s_ram (
		.clk(clk), .we(d2s_we), .waddr(d2s_waddr), .wdata(d2s_wdata),
		.raddr(d2s_raddr), .rdata(d2s_rd)
	);
	ghsm_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_free_ram (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.raddr(free_raddr), .rdata(free_rd)
	);
	ghsm_ram #(.WIDTH(IW+GW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q), .rdata(q_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (op_t'(operation))
						OP_CREATE:  state_d = S_CR_POP;
						OP_DESTROY: state_d = S_DS;
						OP_TICK:    state_d = S_TK_Q;
						default:    state_d = S_LK_RD;
					endcase
				end
			end
			S_CR_POP: begin
				if (free_q != '0) state_d = S_CR_GEN;
				else if (used_q < NW'(MAX_ENTRIES)) state_d = S_CR_WR;
				else state_d = S_DONE;
			end
			S_CR_GEN: state_d = S_CR_RDG;
			S_CR_RDG: state_d = S_CR_WR;
			S_CR_WR:  state_d = S_DONE;
			S_DS:     state_d = S_DONE;
			S_LK_RD:  state_d = lk_in_range ? S_LK_D2S : S_DONE;
			S_LK_D2S: state_d = pos_live ? S_LK_CHK : S_DONE;
			S_LK_CHK: state_d = S_DONE;
			S_TK_Q:   state_d = (cnt_q == '0) ? S_DONE : S_TK_S;
			S_TK_S:   state_d = tk_in_range ? S_TK_D : S_TK_Q;
			S_TK_D:   state_d = pos_live ? S_TK_C : S_TK_Q;
			S_TK_C: begin
				if (!tk_match) state_d = S_TK_Q;
				else if (pos_q != last_pos) state_d = S_TK_M;
				else state_d = S_TK_W;
			end
			S_TK_M:   state_d = S_TK_W;
			S_TK_W:   state_d = S_TK_Q;
			S_DONE:   state_d = out_load ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		pos_we     = 1'b0;
		gen_we     = 1'b0;
		d2s_we     = 1'b0;
		free_we    = 1'b0;
		q_we       = 1'b0;
		pos_waddr  = slot_q;
		pos_wdata  = live_q[IW-1:0];
		gen_waddr  = slot_q;
		gen_wdata  = sgen_q;
		d2s_waddr  = live_q[IW-1:0];
		d2s_wdata  = slot_q;
		free_waddr = free_q[IW-1:0];
		free_wdata = slot_q;
		free_raddr = free_dec[IW-1:0];
		q_waddr    = tail;
		q_wdata    = {idx_q, gen_q};
		sg_raddr   = idx_q;
		d2s_raddr  = pos_rd;
		case (state_q)
			S_CR_GEN: sg_raddr = free_rd;
			S_CR_WR: begin
				pos_we = 1'b1;
				gen_we = 1'b1;
				d2s_we = 1'b1;
			end
			S_DS:   q_we = ds_ok;
			S_TK_S: sg_raddr = q_rd_idx;
			S_TK_C: d2s_raddr = last_pos;
			S_TK_M: begin
				d2s_we    = 1'b1;
				d2s_waddr = pos_q;
				d2s_wdata = d2s_rd;
				pos_we    = 1'b1;
				pos_waddr = d2s_rd;
				pos_wdata = pos_q;
			end
			S_TK_W: begin
				gen_we    = 1'b1;
				gen_wdata = sgen_q + 1'b1;
				free_we   = free_q < NW'(MAX_ENTRIES);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= '0;
			used_q      <= '0;
			live_q      <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CR_POP: begin
					if (free_q != '0) free_q <= free_dec;
					else if (used_q < NW'(MAX_ENTRIES)) used_q <= used_q + 1'b1;
				end
				S_CR_WR: live_q <= live_q + 1'b1;
				S_DS:    if (ds_ok) cnt_q <= cnt_q + 1'b1;
				S_TK_Q: begin
					if (cnt_q != '0) begin
						head_q <= head_inc;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				S_TK_W: begin
					live_q <= last_n;
					if (free_q < NW'(MAX_ENTRIES)) free_q <= free_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q        <= op_t'(operation);
				idx_q       <= handle_index;
				gen_q       <= handle_gen;
				st_q        <= ST_OK;
				res_idx_q   <= '0;
				res_gen_q   <= '0;
				res_dense_q <= '0;
				rm_q        <= '0;
			end
			S_CR_POP: begin
				slot_q <= used_q[IW-1:0];
				sgen_q <= '0;
				if (free_q == '0 && used_q >= NW'(MAX_ENTRIES)) st_q <= ST_TABLE_FULL;
			end
			S_CR_GEN: slot_q <= free_rd;
			S_CR_RDG: sgen_q <= gen_rd;
			S_CR_WR: begin
				res_idx_q   <= slot_q;
				res_gen_q   <= sgen_q;
				res_dense_q <= live_q[IW-1:0];
			end
			S_DS: begin
				if (NW'(idx_q) >= used_q) st_q <= ST_INVALID;
				else if (!ds_ok) st_q <= ST_QUEUE_FULL;
			end
			S_LK_RD: if (!lk_in_range) st_q <= ST_INVALID;
			S_LK_D2S: begin
				pos_q  <= pos_rd;
				sgen_q <= gen_rd;
				if (!pos_live) st_q <= ST_INVALID;
			end
			S_LK_CHK: begin
				if (lk_match) res_dense_q <= pos_q;
				else st_q <= ST_INVALID;
			end
			S_TK_S: begin
				slot_q <= q_rd_idx;
				qgen_q <= q_rd_gen;
			end
			S_TK_D: begin
				pos_q  <= pos_rd;
				sgen_q <= gen_rd;
			end
			S_TK_W: rm_q <= rm_q + 1'b1;
			S_DONE: begin
				if (out_load) begin
					out_status_q <= st_q;
					out_idx_q    <= res_idx_q;
					out_gen_q    <= res_gen_q;
					out_dense_q  <= res_dense_q;
					out_rm_q     <= rm_q;
					out_live_q   <= live_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign out_handle_index = out_idx_q;
	assign out_handle_gen   = out_gen_q;
	assign dense_index      = out_dense_q;
	assign destroyed_count  = out_rm_q;
	assign live_count       = out_live_q;

	// counters only agree between requests
	assign bal_ok  = (state_q != S_IDLE)
		|| (((NW+1)'(free_q) + (NW+1)'(live_q)) == (NW+1)'(used_q));
	assign tk_done = (state_q == S_DONE) && (op_q == OP_TICK);

`include "generational_handle_slot_map_assert.svh"

	`GHSM_ASSERT(a_slot_balance, bal_ok, "free plus live differs from allocated slots")
	`GHSM_ASSERT(a_remove_nonempty, (state_q != S_TK_W) || (live_q != '0), "empty removal")
	`GHSM_ASSERT_NEXT(a_tick_drains, tk_done, cnt_q == '0, "tick left queued handles")

endmodule
